>>> rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants and codes of the modular multiply / exponentiate unit.
// ----------------------------------------------------------------------------
package mme_pkg;

    // Port field widths
    localparam int LOW_WIDTH  = 64;
    localparam int HIGH_WIDTH = 63;
    localparam int FULL_WIDTH = LOW_WIDTH + HIGH_WIDTH;
    localparam int EXP_PORT_WIDTH = 64;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 64;

    // Parameter defaults
    localparam int OPERAND_WIDTH_DEF  = 127;
    localparam int EXPONENT_WIDTH_DEF = 64;

    // Operation codes
    localparam logic FUNC_MUL = 1'b0;
    localparam logic FUNC_POW = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS_LOW  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS_HIGH = 1'b1;

    // Control between sequencer and multiplier
    typedef struct packed {
        logic start;
    } mme_mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mme_mul_sts_t;

endpackage

>>> rtl/core/mme_channels.sv
// ----------------------------------------------------------------------------
// mme channels
// Request, response and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface mme_req_if;
    import mme_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [LOW_WIDTH-1:0]  operand_a_low;
    logic [HIGH_WIDTH-1:0] operand_a_high;
    logic [LOW_WIDTH-1:0]  operand_b_low;
    logic [HIGH_WIDTH-1:0] operand_b_high;
    logic [EXP_PORT_WIDTH-1:0] exponent;

    modport source (output valid, func, operand_a_low, operand_a_high,
                    operand_b_low, operand_b_high, exponent, input ready);
    modport sink   (input valid, func, operand_a_low, operand_a_high,
                    operand_b_low, operand_b_high, exponent, output ready);
endinterface

interface mme_rsp_if;
    import mme_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [LOW_WIDTH-1:0]  result_low;
    logic [HIGH_WIDTH-1:0] result_high;
    logic                  bad_operand;

    modport source (output valid, result_low, result_high, bad_operand, input ready);
    modport sink   (input valid, result_low, result_high, bad_operand, output ready);
endinterface

interface mme_cfg_if;
    import mme_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/mme_modmul.sv
// ----------------------------------------------------------------------------
// mme_modmul
// Bit-serial modular multiplier: add-and-double over the multiplier bits,
// LSB first, one multiplier bit per cycle, one conditional subtract per add.
// ----------------------------------------------------------------------------
module mme_modmul #(
    parameter int WIDTH = mme_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mme_pkg::mme_mul_ctl_t     ctl,
    output mme_pkg::mme_mul_sts_t     sts,
    input  logic [WIDTH-1:0]          addend,
    input  logic [WIDTH-1:0]          multiplier,
    input  logic [WIDTH-1:0]          modulus,
    output logic [WIDTH-1:0]          product
);
    import mme_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] add_reg, add_next;
    logic [WIDTH-1:0] mult_reg, mult_next;
    logic [WIDTH-1:0] acc_sum;
    logic [WIDTH-1:0] add_dbl;

    // (x + y) mod m for x, y below m
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] s;
        logic [WIDTH:0] t;
        s = {1'b0, x} + {1'b0, y};
        t = s - {1'b0, m};
        add_mod = (s >= {1'b0, m}) ? t[WIDTH-1:0] : s[WIDTH-1:0];
    endfunction

    assign acc_sum = add_mod(acc_reg, add_reg, modulus);
    assign add_dbl = add_mod(add_reg, add_reg, modulus);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        add_next  = add_reg;
        mult_next = mult_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            add_next  = addend;
            mult_next = multiplier;
        end
        else if (busy_reg)
        begin
            if (mult_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mult_reg[0])
                begin
                    acc_next = acc_sum;
                end
                add_next  = add_dbl;
                mult_next = mult_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        add_reg  <= add_next;
        mult_reg <= mult_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier done while busy");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg && !done_reg)
        else $error("multiplier started while in use");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a run");

endmodule

>>> rtl/core/modular_multiply_exponentiate_unit.sv
// ----------------------------------------------------------------------------
// modular_multiply_exponentiate_unit
// Modular multiply a*b mod m, or right-to-left square-and-multiply a^e mod m.
// One transaction at a time; the bit-serial multiplier, one multiplier bit per cycle,
// sets the pace. Results wait in an output register.
// Reset: modulus resets to 1, control state clears, no transaction pending.
// ----------------------------------------------------------------------------
module modular_multiply_exponentiate_unit #(
    parameter int OPERAND_WIDTH  = mme_pkg::OPERAND_WIDTH_DEF,
    parameter int EXPONENT_WIDTH = mme_pkg::EXPONENT_WIDTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    mme_cfg_if.sink cfg,
    mme_req_if.sink req,
    mme_rsp_if.source rsp
);
    import mme_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MWAIT = 3'd2;
    localparam logic [2:0] S_EXP   = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_SQ    = 3'd5;
    localparam logic [2:0] S_AWAIT = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                state_reg, state_next;
    logic [LOW_WIDTH-1:0]      mod_low_reg;
    logic [HIGH_WIDTH-1:0]     mod_high_reg;
    logic                      func_reg, func_next;
    logic [OPERAND_WIDTH-1:0]  a_reg, a_next;
    logic [OPERAND_WIDTH-1:0]  b_reg, b_next;
    logic [EXPONENT_WIDTH-1:0] e_reg, e_next;
    logic [OPERAND_WIDTH-1:0]  r_reg, r_next;
    logic                      bad_reg, bad_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    logic [LOW_WIDTH-1:0]      rsp_low_reg, rsp_low_next;
    logic [HIGH_WIDTH-1:0]     rsp_high_reg, rsp_high_next;
    logic                      rsp_bad_reg, rsp_bad_next;

    logic [FULL_WIDTH-1:0]     mod_full;
    logic [FULL_WIDTH-1:0]     a_full;
    logic [FULL_WIDTH-1:0]     b_full;
    logic [FULL_WIDTH-1:0]     res_full;
    logic [OPERAND_WIDTH-1:0]  modulus;
    logic                      check_bad;

    mme_mul_ctl_t              mul_ctl;
    mme_mul_sts_t              mul_sts;
    logic [OPERAND_WIDTH-1:0]  mul_addend;
    logic [OPERAND_WIDTH-1:0]  mul_multiplier;
    logic [OPERAND_WIDTH-1:0]  mul_product;

    assign mod_full = {mod_high_reg, mod_low_reg};
    assign modulus  = mod_full[OPERAND_WIDTH-1:0];
    assign a_full   = {req.operand_a_high, req.operand_a_low};
    assign b_full   = {req.operand_b_high, req.operand_b_low};
    assign res_full = FULL_WIDTH'(r_reg);

    assign check_bad = (modulus == '0) || (a_reg >= modulus) ||
                       ((func_reg == FUNC_MUL) && (b_reg >= modulus));

    // Configuration writes land at once
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_low_reg  <= LOW_WIDTH'(1);
            mod_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MODULUS_LOW:  mod_low_reg  <= cfg.data;
                REG_MODULUS_HIGH: mod_high_reg <= cfg.data[HIGH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        r_next         = r_reg;
        bad_next       = bad_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_low_next   = rsp_low_reg;
        rsp_high_next  = rsp_high_reg;
        rsp_bad_next   = rsp_bad_reg;
        mul_ctl.start  = 1'b0;
        mul_addend     = a_reg;
        mul_multiplier = b_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    a_next     = a_full[OPERAND_WIDTH-1:0];
                    b_next     = b_full[OPERAND_WIDTH-1:0];
                    e_next     = req.exponent[EXPONENT_WIDTH-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                bad_next = check_bad;
                if (check_bad)
                begin
                    r_next     = '0;
                    state_next = S_DONE;
                end
                else if (func_reg == FUNC_MUL)
                begin
                    mul_ctl.start = 1'b1;
                    state_next    = S_MWAIT;
                end
                else
                begin
                    r_next     = (modulus == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
                    state_next = S_EXP;
                end
            end
            S_MWAIT:
            begin
                if (mul_sts.done)
                begin
                    r_next     = mul_product;
                    state_next = S_DONE;
                end
            end
            S_EXP:
            begin
                mul_addend     = r_reg;
                mul_multiplier = a_reg;
                if (e_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (e_reg[0])
                begin
                    mul_ctl.start = 1'b1;
                    state_next    = S_RWAIT;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_RWAIT:
            begin
                if (mul_sts.done)
                begin
                    r_next     = mul_product;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                mul_addend     = a_reg;
                mul_multiplier = a_reg;
                e_next         = e_reg >> 1;
                // square the base only while exponent bits remain
                if ((e_reg >> 1) != '0)
                begin
                    mul_ctl.start = 1'b1;
                    state_next    = S_AWAIT;
                end
                else
                begin
                    state_next = S_EXP;
                end
            end
            S_AWAIT:
            begin
                if (mul_sts.done)
                begin
                    a_next     = mul_product;
                    state_next = S_EXP;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_low_next   = res_full[LOW_WIDTH-1:0];
                    rsp_high_next  = res_full[FULL_WIDTH-1:LOW_WIDTH];
                    rsp_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        e_reg        <= e_next;
        r_reg        <= r_next;
        bad_reg      <= bad_next;
        rsp_low_reg  <= rsp_low_next;
        rsp_high_reg <= rsp_high_next;
        rsp_bad_reg  <= rsp_bad_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.result_low  = rsp_low_reg;
    assign rsp.result_high = rsp_high_reg;
    assign rsp.bad_operand = rsp_bad_reg;

    mme_modmul #(
        .WIDTH (OPERAND_WIDTH)
    ) u_modmul (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mul_ctl),
        .sts        (mul_sts),
        .addend     (mul_addend),
        .multiplier (mul_multiplier),
        .modulus    (modulus),
        .product    (mul_product)
    );

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.done |-> (state_reg == S_MWAIT) || (state_reg == S_RWAIT) ||
                         (state_reg == S_AWAIT))
        else $error("multiplier result outside a wait state");

    a_square_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ) |-> (e_reg != '0))
        else $error("square step with exhausted exponent");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_bad_reg) |-> (rsp_low_reg == '0) && (rsp_high_reg == '0))
        else $error("flagged transaction carries a nonzero result");

    a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MWAIT) && !mul_sts.done) |-> mul_sts.busy)
        else $error("waiting on an idle multiplier");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for modular_multiply_exponentiate_unit
// Sends multiply and power requests under several moduli (reset value one,
// zero, the largest, 2^64, small and random) and checks each response against
// residues given per row or computed here by add-and-double and square-and-multiply.
// ----------------------------------------------------------------------------
module testbench;
    import mme_pkg::*;

    typedef logic [FULL_WIDTH-1:0] wide_t;

    typedef struct {
        logic                      func;
        wide_t                     a;
        wide_t                     b;
        logic [EXP_PORT_WIDTH-1:0] e;
    } mme_op_t;

    typedef struct {
        wide_t value;
        logic  bad;
    } residue_t;

    typedef struct {
        wide_t    modulus;
        mme_op_t  op;
        bit       typed;
        residue_t want;
    } stim_row_t;

    localparam wide_t MAX_MOD = '1;
    localparam wide_t TOP_BIT = wide_t'(1) << (FULL_WIDTH - 1);
    localparam wide_t MOD_2_64 = wide_t'(1) << LOW_WIDTH;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mme_cfg_if cfg_if ();
    mme_req_if req_if ();
    mme_rsp_if rsp_if ();

    modular_multiply_exponentiate_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Modulus as the block holds it; one after reset
    wide_t     modulus = wide_t'(1);
    residue_t  pending_residues[$];
    stim_row_t directed_rows[$];
    int        errors = 0;
    bit        calm = 1'b0;
    bit        stall_request = 1'b0;

    always #5 clk = ~clk;

    function automatic wide_t rand_wide();
        return wide_t'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic wide_t mod_add(wide_t x, wide_t y, wide_t m);
        logic [FULL_WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[FULL_WIDTH-1:0];
    endfunction

    // Add-and-double, multiplier bits LSB first
    function automatic wide_t mod_mul(wide_t a, wide_t b, wide_t m);
        wide_t acc;
        acc = '0;
        while (b != 0)
        begin
            if (b[0])
            begin
                acc = mod_add(acc, a, m);
            end
            b = b >> 1;
            if (b != 0)
            begin
                a = mod_add(a, a, m);
            end
        end
        return acc;
    endfunction

    // Right-to-left square-and-multiply
    function automatic wide_t mod_pow(wide_t base, logic [EXP_PORT_WIDTH-1:0] e, wide_t m);
        wide_t acc;
        acc = (m == 1) ? '0 : wide_t'(1);
        while (e != 0)
        begin
            if (e[0])
            begin
                acc = mod_mul(acc, base, m);
            end
            e = e >> 1;
            if (e != 0)
            begin
                base = mod_mul(base, base, m);
            end
        end
        return acc;
    endfunction

    function automatic residue_t predict_residue(mme_op_t op, wide_t m);
        residue_t r;
        r.value = '0;
        r.bad = (m == 0) || (op.a >= m) || (op.func == FUNC_MUL && op.b >= m);
        if (!r.bad)
        begin
            r.value = (op.func == FUNC_MUL) ? mod_mul(op.a, op.b, m) : mod_pow(op.a, op.e, m);
        end
        return r;
    endfunction

    // Mostly in range, with zero, m-1 and raw values mixed in
    function automatic wide_t pick_operand(wide_t m);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            return '0;
        end
        if (roll < 10)
        begin
            return m - 1;
        end
        if (roll < 16 || m == 0)
        begin
            return rand_wide();
        end
        return rand_wide() % m;
    endfunction

    task automatic add_row(wide_t m, logic func, wide_t a, wide_t b,
                           logic [EXP_PORT_WIDTH-1:0] e, bit typed,
                           wide_t want_value, logic want_bad);
        stim_row_t row;
        row.modulus    = m;
        row.op.func    = func;
        row.op.a       = a;
        row.op.b       = b;
        row.op.e       = e;
        row.typed      = typed;
        row.want.value = want_value;
        row.want.bad   = want_bad;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Write both modulus registers once the block has drained
    task automatic set_modulus(wide_t m, bit spare);
        req_if.valid <= 1'b0;
        while (pending_residues.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_MODULUS_LOW;
        cfg_if.data  <= m[LOW_WIDTH-1:0];
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.index <= REG_MODULUS_HIGH;
        cfg_if.data  <= {spare, m[FULL_WIDTH-1:LOW_WIDTH]};
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        modulus = m;
    endtask

    task automatic send_item(mme_op_t op, bit typed, residue_t want);
        residue_t due;
        due = typed ? want : predict_residue(op, modulus);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.func           <= op.func;
        req_if.operand_a_low  <= op.a[LOW_WIDTH-1:0];
        req_if.operand_a_high <= op.a[FULL_WIDTH-1:LOW_WIDTH];
        req_if.operand_b_low  <= op.b[LOW_WIDTH-1:0];
        req_if.operand_b_high <= op.b[FULL_WIDTH-1:LOW_WIDTH];
        req_if.exponent       <= op.e;
        do @(posedge clk); while (!req_if.ready);
        pending_residues.insert(pending_residues.size(), due);
    endtask

    // Response side: random back-pressure, plus one long hold on request
    initial
    begin : drain
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                stall_left = 600;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= calm || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_residues.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected response: high %h low %h bad %b",
                             rsp_if.result_high, rsp_if.result_low, rsp_if.bad_operand);
                end
            end
            else if (rsp_if.result_low !== pending_residues[0].value[LOW_WIDTH-1:0] ||
                     rsp_if.result_high !== pending_residues[0].value[FULL_WIDTH-1:LOW_WIDTH] ||
                     rsp_if.bad_operand !== pending_residues[0].bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected %h bad %b, got high %h low %h bad %b",
                             pending_residues[0].value, pending_residues[0].bad,
                             rsp_if.result_high, rsp_if.result_low, rsp_if.bad_operand);
                end
            end
            if (pending_residues.size() != 0)
            begin
                void'(pending_residues.pop_front());
            end
        end
    end

    initial
    begin : stimulus
        mme_op_t  op;
        residue_t unused;
        wide_t    m;
        req_if.valid          = 1'b0;
        req_if.func           = FUNC_MUL;
        req_if.operand_a_low  = '0;
        req_if.operand_a_high = '0;
        req_if.operand_b_low  = '0;
        req_if.operand_b_high = '0;
        req_if.exponent       = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_MODULUS_LOW;
        cfg_if.data           = '0;
        unused.value          = '0;
        unused.bad            = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Modulus one straight out of reset
        add_row(1, FUNC_MUL, 0, 0, '1, 1, 0, 0);
        add_row(1, FUNC_POW, 0, 0, 0, 1, 0, 0);
        add_row(1, FUNC_MUL, 1, 0, 0, 1, 0, 1);
        // Zero modulus
        add_row(0, FUNC_MUL, 0, 0, 0, 1, 0, 1);
        add_row(0, FUNC_POW, 0, 0, 5, 1, 0, 1);
        // Largest modulus, 2^127 - 1
        add_row(MAX_MOD, FUNC_MUL, MAX_MOD - 1, MAX_MOD - 1, 0, 1, 1, 0);
        add_row(MAX_MOD, FUNC_MUL, MAX_MOD, 0, 0, 1, 0, 1);
        add_row(MAX_MOD, FUNC_MUL, 0, MAX_MOD, 0, 1, 0, 1);
        add_row(MAX_MOD, FUNC_MUL, 0, MAX_MOD - 1, '1, 1, 0, 0);
        add_row(MAX_MOD, FUNC_MUL, TOP_BIT, 2, 0, 1, 1, 0);
        add_row(MAX_MOD, FUNC_POW, MAX_MOD - 1, 0, 0, 1, 1, 0);
        add_row(MAX_MOD, FUNC_POW, MAX_MOD - 1, 0, '1, 1, MAX_MOD - 1, 0);
        add_row(MAX_MOD, FUNC_POW, MAX_MOD, 0, 3, 1, 0, 1);
        add_row(MAX_MOD, FUNC_POW, 5, MAX_MOD, 2, 1, 25, 0);
        add_row(MAX_MOD, FUNC_POW, 2, 0, 127, 1, 1, 0);
        add_row(MAX_MOD, FUNC_MUL, rand_wide() >> 1, rand_wide() >> 1, 0, 0, 0, 0);
        add_row(MAX_MOD, FUNC_POW, rand_wide() >> 1, 0, 64'h8000_0000_0000_0001, 0, 0, 0);
        // Small modulus
        add_row(3, FUNC_POW, 2, 0, 0, 1, 1, 0);
        add_row(3, FUNC_MUL, 2, 2, 0, 1, 1, 0);
        add_row(3, FUNC_MUL, 3, 1, 0, 1, 0, 1);
        // Modulus 2^64, carry across the halves
        add_row(MOD_2_64, FUNC_MUL, wide_t'(1) << 63, 2, 0, 1, 0, 0);
        add_row(MOD_2_64, FUNC_MUL, MOD_2_64 - 1, MOD_2_64 - 1, 0, 0, 0, 0);
        add_row(MOD_2_64, FUNC_POW, wide_t'(1) << 32, 0, 2, 1, 0, 0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].modulus !== modulus)
            begin
                set_modulus(directed_rows[i].modulus, directed_rows[i].modulus == MAX_MOD);
            end
            send_item(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: m = rand_wide();
                1: m = wide_t'({$urandom, $urandom});
                2: m = wide_t'($urandom_range(2, 1000));
                default: m = rand_wide() | TOP_BIT;
            endcase
            set_modulus(m, $urandom_range(0, 1));
            calm = (phase == 1);
            if (phase == 2)
            begin
                stall_request = 1'b1;
            end
            repeat (20)
            begin
                op.func = ($urandom_range(0, 99) < 25) ? FUNC_POW : FUNC_MUL;
                op.a = pick_operand(m);
                op.b = (op.func == FUNC_POW) ? rand_wide() : pick_operand(m);
                op.e = {$urandom, $urandom};
                // Keep most exponents short; full width now and then
                if (op.func == FUNC_POW && $urandom_range(0, 99) >= 15)
                begin
                    op.e = op.e >> $urandom_range(32, 63);
                end
                send_item(op, 1'b0, unused);
            end
        end
        calm = 1'b0;
        req_if.valid <= 1'b0;

        while (pending_residues.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mme_pkg.sv
rtl/core/mme_channels.sv
rtl/core/mme_modmul.sv
rtl/core/modular_multiply_exponentiate_unit.sv
tb/sv/testbench.sv
